// ===== rtl/software_timer_table_top_macros.svh =====
// assertion helpers for the timer table
`ifndef SOFTWARE_TIMER_TABLE_TOP_MACROS_SVH
`define SOFTWARE_TIMER_TABLE_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/stt_pkg.sv =====
`timescale 1ns / 1ps
package stt_pkg;

  // field widths of the stream payload
  localparam int CMD_W    = 3;
  localparam int SLOT_F_W = 4;
  localparam int DUR_W    = 32;
  localparam int NOW_W    = 48;
  localparam int STAT_W   = 2;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 8;

  // defaults for the top level parameters
  localparam int DEF_NUM_SLOTS = 16;
  localparam int DEF_TIME_BITS = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 3'd0,
    CMD_ARM_ONE = 3'd1,
    CMD_ARM_PER = 3'd2,
    CMD_CANCEL  = 3'd3,
    CMD_FREE    = 3'd4,
    CMD_TICK    = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_FREE    = 2'd1,
    ST_NOT_ACTIVE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CMD,
    S_ALLOC,
    S_TICK_RD,
    S_TICK_EV,
    S_FLUSH
  } state_t;

endpackage

// ===== rtl/software_timer_table_top.sv =====
`timescale 1ns / 1ps
// channel | dir | tdata (low bit up)                                | tuser  | tlast
// in_     | in  | timer_slot[3:0] duration_ms[35:4] notify[36]     | cmd    | -
//         |     | now_ms[84:37], zero pad to 88                     |        |
// out_    | out | result_slot[3:0] status[5:4], zero pad to 8       | fired  | last
//
// one request at a time; arm, cancel and free are answered from the command
// state, allocate scans from slot 0 (one slot checked per cycle), and a tick
// visits the slots in turn through the single read port of the expiry/period
// memory (read in one state, evaluate and write back in the next). Output
// stalls hold the sequencer only where a result has to leave. Synchronous
// active-low reset clears the slot flags and control; the memory needs no
// clearing, the armed flag marks its valid entries.
module software_timer_table_top #(
  parameter int NUM_SLOTS = stt_pkg::DEF_NUM_SLOTS,
  parameter int TIME_BITS = stt_pkg::DEF_TIME_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // timer_slot, duration_ms, notify_enable, now_ms
  input  logic [stt_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd
  input  logic [stt_pkg::CMD_W-1:0]      in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // result_slot, status
  output logic [stt_pkg::OUT_DATA_W-1:0] out_tdata,
  // fired
  output logic                           out_tuser,
  output logic                           out_tlast
);
  import stt_pkg::*;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int MEM_W  = DUR_W + TIME_BITS;
  localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(NUM_SLOTS - 1);

  // control and slot flags
  state_t                  state_r, state_nxt;
  logic [SLOT_W-1:0]       idx_r, idx_nxt;
  logic [NUM_SLOTS-1:0]    active_r, active_nxt;
  logic [NUM_SLOTS-1:0]    notify_r, notify_nxt;
  logic [NUM_SLOTS-1:0]    armed_r, armed_nxt;
  logic                    pend_v_r, pend_v_nxt;
  logic [SLOT_F_W-1:0]     pend_slot_r, pend_slot_nxt;

  // latched request
  cmd_t                    cmd_r;
  logic [SLOT_F_W-1:0]     slot_r;
  logic [DUR_W-1:0]        dur_r;
  logic                    notif_r;
  logic [TIME_BITS-1:0]    now_r;

  // output register
  logic                    out_valid_r;
  logic [SLOT_F_W-1:0]     out_slot_r;
  status_t                 out_status_r;
  logic                    out_fired_r;
  logic                    out_last_r;

  // memory: {period, expiry} per slot
  logic [MEM_W-1:0]        tmr_mem [NUM_SLOTS];
  logic [MEM_W-1:0]        rd_r;
  logic                    mem_we;
  logic [SLOT_W-1:0]       mem_wa;
  logic [MEM_W-1:0]        mem_wd;

  // datapath signals
  logic                    in_acc;
  logic                    out_free;
  logic [NOW_W+TIME_BITS-1:0] now_wide;
  logic [SLOT_W+SLOT_F_W-1:0] slot_wide;
  logic [SLOT_W+SLOT_F_W-1:0] idx_wide;
  logic [SLOT_W-1:0]       slot_idx;
  logic [SLOT_F_W-1:0]     idx_res;
  logic                    in_range;
  logic [DUR_W-1:0]        rd_period;
  logic [TIME_BITS-1:0]    rd_exp;
  logic [DUR_W-1:0]        addend;
  logic [TIME_BITS:0]      sum;
  logic [TIME_BITS-1:0]    sum_sat;
  logic                    fire;
  logic                    need_emit;
  logic                    push;
  logic [SLOT_F_W-1:0]     push_slot;
  status_t                 push_status;
  logic                    push_fired;
  logic                    push_last;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign now_wide  = {TIME_BITS'(0), in_tdata[84:37]};
  assign slot_wide = {SLOT_W'(0), slot_r};
  assign slot_idx  = slot_wide[SLOT_W-1:0];
  assign in_range  = slot_wide < (SLOT_W+SLOT_F_W)'(NUM_SLOTS);
  assign idx_wide  = {SLOT_F_W'(0), idx_r};
  assign idx_res   = idx_wide[SLOT_F_W-1:0];

  assign rd_period = rd_r[MEM_W-1:TIME_BITS];
  assign rd_exp    = rd_r[TIME_BITS-1:0];

  // shared saturating add: period on a tick, duration on an arm
  assign addend  = (state_r == S_TICK_EV) ? rd_period : dur_r;
  assign sum     = {1'b0, now_r} + (TIME_BITS+1)'(addend);
  assign sum_sat = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];

  assign fire      = active_r[idx_r] & armed_r[idx_r] & (now_r >= rd_exp);
  assign need_emit = fire & notify_r[idx_r];

  // latch the request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= cmd_t'(in_tuser);
      slot_r  <= in_tdata[3:0];
      dur_r   <= in_tdata[35:4];
      notif_r <= in_tdata[36];
      now_r   <= now_wide[TIME_BITS-1:0];
    end
  end

  // timer memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tmr_mem[mem_wa] <= mem_wd;
    end
    rd_r <= tmr_mem[idx_r];
  end

  // state and flag registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      idx_r    <= '0;
      active_r <= '0;
      notify_r <= '0;
      armed_r  <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      active_r <= active_nxt;
      notify_r <= notify_nxt;
      armed_r  <= armed_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_slot_r <= pend_slot_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    active_nxt    = active_r;
    notify_nxt    = notify_r;
    armed_nxt     = armed_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    mem_we        = 1'b0;
    mem_wa        = idx_r;
    mem_wd        = {rd_period, sum_sat};
    push          = 1'b0;
    push_slot     = slot_r;
    push_status   = ST_OK;
    push_fired    = 1'b0;
    push_last     = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          idx_nxt = '0;
          case (in_tuser) inside
            CMD_ALLOC: state_nxt = S_ALLOC;
            CMD_ARM_ONE, CMD_ARM_PER, CMD_CANCEL, CMD_FREE: state_nxt = S_CMD;
            CMD_TICK: state_nxt = S_TICK_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CMD: begin
        if (out_free) begin
          push      = 1'b1;
          state_nxt = S_IDLE;
          case (cmd_r) inside
            CMD_ARM_ONE, CMD_ARM_PER: begin
              if (in_range && active_r[slot_idx]) begin
                mem_we = 1'b1;
                mem_wa = slot_idx;
                mem_wd = {(cmd_r == CMD_ARM_PER) ? dur_r : DUR_W'(0), sum_sat};
                armed_nxt[slot_idx] = 1'b1;
              end else begin
                push_status = ST_NOT_ACTIVE;
              end
            end
            CMD_CANCEL: begin
              if (in_range) begin
                armed_nxt[slot_idx] = 1'b0;
              end else begin
                push_status = ST_NOT_ACTIVE;
              end
            end
            CMD_FREE: begin
              if (in_range) begin
                active_nxt[slot_idx] = 1'b0;
              end else begin
                push_status = ST_NOT_ACTIVE;
              end
            end
            default: push = 1'b0;
          endcase
        end
      end
      S_ALLOC: begin
        // first free slot, one per cycle
        if (!active_r[idx_r]) begin
          if (out_free) begin
            push                = 1'b1;
            push_slot           = idx_res;
            active_nxt[idx_r]   = 1'b1;
            notify_nxt[idx_r]   = notif_r;
            armed_nxt[idx_r]    = 1'b0;
            state_nxt           = S_IDLE;
          end
        end else if (idx_r == LAST_IDX) begin
          if (out_free) begin
            push        = 1'b1;
            push_slot   = '0;
            push_status = ST_NO_FREE;
            state_nxt   = S_IDLE;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_TICK_RD: begin
        state_nxt = S_TICK_EV;
      end
      S_TICK_EV: begin
        // a new notifying fire pushes the held one out, so the output must have room
        if (!(need_emit && pend_v_r) || out_free) begin
          if (fire) begin
            if (rd_period != '0) begin
              mem_we = 1'b1;
            end else begin
              armed_nxt[idx_r] = 1'b0;
            end
          end
          if (need_emit) begin
            if (pend_v_r) begin
              push       = 1'b1;
              push_slot  = pend_slot_r;
              push_fired = 1'b1;
              push_last  = 1'b0;
            end
            pend_v_nxt    = 1'b1;
            pend_slot_nxt = idx_res;
          end
          if (idx_r == LAST_IDX) begin
            state_nxt = S_FLUSH;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_TICK_RD;
          end
        end
      end
      S_FLUSH: begin
        // the held fire is the final one of the tick
        if (!pend_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          push       = 1'b1;
          push_slot  = pend_slot_r;
          push_fired = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_slot_r   <= push_slot;
      out_status_r <= push_status;
      out_fired_r  <= push_fired;
      out_last_r   <= push_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_status_r, out_slot_r};
  assign out_tuser  = out_fired_r;
  assign out_tlast  = out_last_r;

  // checks
`include "software_timer_table_top_macros.svh"

  `STT_ASSERT_NOW(a_pend_in_tick, pend_v_r, (state_r == S_TICK_RD || state_r == S_TICK_EV || state_r == S_FLUSH), "held fire outside a tick")
  `STT_ASSERT_NEXT(a_flush_done, (state_r == S_FLUSH && !pend_v_r), (state_r == S_IDLE), "flush did not finish")
  `STT_ASSERT_NOW(a_fire_ok, (out_valid_r && out_fired_r), (out_status_r == ST_OK), "fire result with bad status")
  `STT_ASSERT_NOW(a_idx_range, 1'b1, (idx_r <= LAST_IDX), "slot index out of range")

endmodule

// ===== tb/sv/timer_table_sb_pkg.sv =====
`timescale 1ns / 1ps
package timer_table_sb_pkg;
  import stt_pkg::*;

  localparam int SLOT_COUNT = DEF_NUM_SLOTS;
  localparam int TIME_W = DEF_TIME_BITS;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // one command request as it enters the table
  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [SLOT_F_W-1:0] slot;
    logic [DUR_W-1:0]    duration;
    logic                notify;
    logic [NOW_W-1:0]    now;
  } timer_request_t;

  // one result as it leaves the table
  typedef struct {
    logic                fired;
    logic [SLOT_F_W-1:0] slot;
    logic [STAT_W-1:0]   status;
    logic                last;
  } timer_result_t;

  class timer_table_sb;
    bit                in_use  [SLOT_COUNT];
    bit                reports [SLOT_COUNT];
    bit                armed   [SLOT_COUNT];
    logic [TIME_W-1:0] due_at  [SLOT_COUNT];
    logic [DUR_W-1:0]  reload  [SLOT_COUNT];
    timer_result_t     owed_results[$];
    int unsigned       mismatches;
    int unsigned       checked;
    int unsigned       fires;
    int unsigned       most_fires;

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        in_use[i]  = 1'b0;
        reports[i] = 1'b0;
        armed[i]   = 1'b0;
        due_at[i]  = '0;
        reload[i]  = '0;
      end
      mismatches = 0;
      checked    = 0;
      fires      = 0;
      most_fires = 0;
    endfunction

    // now plus a delay, pinned at the top of the time range
    function logic [TIME_W-1:0] deadline(logic [TIME_W-1:0] base, logic [DUR_W-1:0] dly);
      logic [TIME_W:0] sum;
      sum = {1'b0, base} + {{(TIME_W+1-DUR_W){1'b0}}, dly};
      return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    endfunction

    function void owe(logic fired, logic [SLOT_F_W-1:0] slot, logic [STAT_W-1:0] status,
                      logic last);
      timer_result_t r;
      r.fired  = fired;
      r.slot   = slot;
      r.status = status;
      r.last   = last;
      owed_results.push_back(r);
    endfunction

    // advance the table by one accepted request and queue what it owes
    function void apply_request(timer_request_t req);
      logic [TIME_W-1:0] now;
      int                first_free;
      int unsigned       hit;
      bit                in_range;
      now = req.now[TIME_W-1:0];
      in_range = int'(req.slot) < SLOT_COUNT;
      case (req.cmd)
        CMD_ALLOC: begin
          first_free = -1;
          for (int i = 0; i < SLOT_COUNT; i++)
            if (!in_use[i] && first_free < 0) first_free = i;
          if (first_free < 0) begin
            owe(1'b0, '0, ST_NO_FREE, 1'b1);
          end else begin
            in_use[first_free]  = 1'b1;
            reports[first_free] = req.notify;
            armed[first_free]   = 1'b0;
            due_at[first_free]  = '0;
            reload[first_free]  = '0;
            owe(1'b0, SLOT_F_W'(first_free), ST_OK, 1'b1);
          end
        end
        CMD_ARM_ONE, CMD_ARM_PER: begin
          if (!in_range || !in_use[req.slot]) begin
            owe(1'b0, req.slot, ST_NOT_ACTIVE, 1'b1);
          end else begin
            due_at[req.slot] = deadline(now, req.duration);
            armed[req.slot]  = 1'b1;
            reload[req.slot] = (req.cmd == CMD_ARM_PER) ? req.duration : '0;
            owe(1'b0, req.slot, ST_OK, 1'b1);
          end
        end
        CMD_CANCEL: begin
          if (!in_range) begin
            owe(1'b0, req.slot, ST_NOT_ACTIVE, 1'b1);
          end else begin
            armed[req.slot]  = 1'b0;
            due_at[req.slot] = '0;
            reload[req.slot] = '0;
            owe(1'b0, req.slot, ST_OK, 1'b1);
          end
        end
        CMD_FREE: begin
          if (!in_range) begin
            owe(1'b0, req.slot, ST_NOT_ACTIVE, 1'b1);
          end else begin
            in_use[req.slot] = 1'b0;
            owe(1'b0, req.slot, ST_OK, 1'b1);
          end
        end
        CMD_TICK: begin
          hit = 0;
          // scan upward, expired slots reload or disarm
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (in_use[i] && armed[i] && now >= due_at[i]) begin
              if (reload[i] != '0) begin
                due_at[i] = deadline(now, reload[i]);
              end else begin
                armed[i]  = 1'b0;
                due_at[i] = '0;
              end
              if (reports[i]) begin
                owe(1'b1, SLOT_F_W'(i), ST_OK, 1'b0);
                hit++;
              end
            end
          end
          if (hit > 0) owed_results[owed_results.size()-1].last = 1'b1;
          fires += hit;
          if (hit > most_fires) most_fires = hit;
        end
        default: begin
          // unknown commands leave no trace
        end
      endcase
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("field %s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    // compare one result against the oldest owed one
    function void check_result(logic fired, logic [SLOT_F_W-1:0] slot,
                               logic [STAT_W-1:0] status, logic last);
      timer_result_t want;
      if (owed_results.size() == 0) begin
        $error("result with nothing owed: fired %0d slot %0d status %0d last %0d",
               fired, slot, status, last);
        mismatches++;
        return;
      end
      want = owed_results.pop_front();
      checked++;
      compare_field("fired", 8'(want.fired), 8'(fired));
      compare_field("result_slot", 8'(want.slot), 8'(slot));
      compare_field("status", 8'(want.status), 8'(status));
      compare_field("last", 8'(want.last), 8'(last));
    endfunction
  endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import stt_pkg::*;
  import timer_table_sb_pkg::*;

  localparam int     CLK_HALF     = 6;
  localparam int     RESET_CYCLES = 12;
  localparam int     RANDOM_ITEMS = 420;
  localparam int     DRAIN_CYCLES = 2 * SLOT_COUNT + 8;
  localparam int     LONG_HOLD    = 400;
  localparam longint TIMEOUT_NS   = 64'd18_000_000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  timer_table_sb    table_sb;
  logic [NOW_W-1:0] clock_ms = '0;
  int unsigned      sent = 0;
  int unsigned      useful = 0;
  bit               hold_off_req = 1'b0;
  bit               hold_off_done = 1'b0;

  software_timer_table_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    // timer_slot, duration_ms, notify_enable, now_ms
    .in_tdata   (in_tdata),
    // cmd
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // result_slot, status
    .out_tdata  (out_tdata),
    // fired
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #CLK_HALF clk = ~clk;

  // sender gap: calm stretches, else mostly short with a few long ones
  function automatic int pick_gap(int unsigned idx);
    int r;
    if ((idx % 80) < 20) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic timer_request_t make_req(logic [CMD_W-1:0] cmd, logic [SLOT_F_W-1:0] slot,
                                              logic [DUR_W-1:0] dur, logic notify,
                                              logic [NOW_W-1:0] now);
    timer_request_t req;
    req.cmd      = cmd;
    req.slot     = slot;
    req.duration = dur;
    req.notify   = notify;
    req.now      = now;
    return req;
  endfunction

  // one random command, steered mostly at allocated slots
  function automatic timer_request_t random_request();
    timer_request_t req;
    int             pick;
    int             live[$];
    for (int i = 0; i < SLOT_COUNT; i++)
      if (table_sb.in_use[i]) live.push_back(i);
    // time mostly creeps forward, now and then it jumps
    pick = $urandom_range(0, 59);
    if (pick == 0)
      clock_ms = {16'($urandom()), $urandom()};
    else if (pick == 1)
      clock_ms = TIME_MAX - NOW_W'($urandom_range(0, 40));
    else
      clock_ms = clock_ms + NOW_W'($urandom_range(0, 6));
    req.now = ($urandom_range(0, 19) == 0) ? {16'($urandom()), $urandom()} : clock_ms;
    req.notify = ($urandom_range(0, 3) != 0);
    req.duration = ($urandom_range(0, 9) == 0) ? $urandom() : DUR_W'($urandom_range(0, 24));
    if (live.size() > 0 && $urandom_range(0, 4) != 0)
      req.slot = SLOT_F_W'(live[$urandom_range(0, live.size() - 1)]);
    else
      req.slot = SLOT_F_W'($urandom_range(0, SLOT_COUNT - 1));
    pick = $urandom_range(0, 99);
    if (pick < 10)      req.cmd = CMD_ALLOC;
    else if (pick < 25) req.cmd = CMD_ARM_ONE;
    else if (pick < 42) req.cmd = CMD_ARM_PER;
    else if (pick < 48) req.cmd = CMD_CANCEL;
    else if (pick < 55) req.cmd = CMD_FREE;
    else if (pick < 97) req.cmd = CMD_TICK;
    else                req.cmd = CMD_W'($urandom_range(6, 7));
    return req;
  endfunction

  // offer one request, wait for the handshake, then idle for a gap
  task automatic send_request(input timer_request_t req);
    int gap;
    in_tdata  <= {{(IN_DATA_W - NOW_W - 1 - DUR_W - SLOT_F_W){1'b0}},
                  req.now, req.notify, req.duration, req.slot};
    in_tuser  <= req.cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    table_sb.apply_request(req);
    sent++;
    if (req.cmd <= CMD_TICK) useful++;
    gap = pick_gap(sent);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      table_sb.check_result(out_tuser, out_tdata[SLOT_F_W-1:0],
                            out_tdata[SLOT_F_W+STAT_W-1:SLOT_F_W], out_tlast);
  end

  // receiver: random stalls, calm stretches, one long hold-off on request
  initial begin : result_sink
    int stall_left;
    int unsigned cyc;
    stall_left = 0;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (hold_off_req && !hold_off_done && out_tvalid) begin
        stall_left = LONG_HOLD;
        hold_off_done = 1'b1;
      end else if (stall_left == 0 && (cyc % 300) >= 60 && $urandom_range(0, 5) == 0) begin
        stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3)
                                                  : $urandom_range(10, 40);
      end
      if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAIL software_timer_table_top");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_base;
    bit          first_episode;
    bit          all_notify;
    int          run_len;
    table_sb = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty tick, zero-time arm, saturation, inactive slots, unknown cmds
    send_request(make_req(CMD_TICK, 4'd0, '0, 1'b0, '0));
    send_request(make_req(CMD_ALLOC, 4'd0, '0, 1'b1, '0));
    send_request(make_req(CMD_ALLOC, 4'd0, '0, 1'b0, '0));
    send_request(make_req(CMD_ARM_ONE, 4'd0, '0, 1'b0, '0));
    send_request(make_req(CMD_ARM_PER, 4'd1, '1, 1'b0, TIME_MAX - 48'd5));
    send_request(make_req(CMD_ARM_ONE, 4'd9, 32'd3, 1'b1, 48'd1));
    send_request(make_req(CMD_ARM_PER, 4'd15, 32'd3, 1'b1, 48'd1));
    send_request(make_req(CMD_TICK, 4'd0, '0, 1'b0, '0));
    // periodic with zero period acts as one-shot
    send_request(make_req(CMD_ARM_PER, 4'd0, '0, 1'b0, 48'd100));
    send_request(make_req(CMD_TICK, 4'd0, '0, 1'b0, 48'd100));
    // periodic reload pinned at the top of the time range
    send_request(make_req(CMD_ARM_PER, 4'd0, 32'd1, 1'b0, TIME_MAX));
    send_request(make_req(CMD_TICK, 4'd0, '0, 1'b0, TIME_MAX));
    send_request(make_req(CMD_TICK, 4'd0, '0, 1'b0, TIME_MAX));
    send_request(make_req(CMD_CANCEL, 4'd1, '0, 1'b0, '0));
    send_request(make_req(CMD_CANCEL, 4'd12, '0, 1'b0, '0));
    send_request(make_req(CMD_FREE, 4'd1, '0, 1'b0, '0));
    send_request(make_req(CMD_FREE, 4'd13, '0, 1'b0, '0));
    send_request(make_req(3'd6, 4'd2, '1, 1'b1, TIME_MAX));
    send_request(make_req(3'd7, 4'd3, '0, 1'b0, '0));

    // random episodes; the first always rebuilds the whole table
    random_base = useful;
    first_episode = 1'b1;
    while (useful - random_base < RANDOM_ITEMS) begin
      if (!hold_off_req && useful - random_base >= 100) hold_off_req = 1'b1;
      if (first_episode || $urandom_range(0, 99) < 8) begin
        // rebuild: empty, refill past capacity, arm every slot, then tick
        all_notify = $urandom_range(0, 1);
        for (int s = 0; s < SLOT_COUNT; s++)
          send_request(make_req(CMD_FREE, SLOT_F_W'(s), $urandom(), 1'($urandom()), clock_ms));
        for (int s = 0; s <= SLOT_COUNT; s++)
          send_request(make_req(CMD_ALLOC, SLOT_F_W'($urandom()), $urandom(),
                                all_notify | 1'($urandom()), clock_ms));
        for (int s = 0; s < SLOT_COUNT; s++)
          send_request(make_req($urandom_range(0, 1) ? CMD_ARM_PER : CMD_ARM_ONE,
                                SLOT_F_W'(s), DUR_W'($urandom_range(0, 3)), 1'($urandom()),
                                clock_ms));
        clock_ms = clock_ms + 48'd4;
        send_request(make_req(CMD_TICK, SLOT_F_W'($urandom()), $urandom(), 1'($urandom()),
                              clock_ms));
        first_episode = 1'b0;
      end else begin
        run_len = $urandom_range(10, 30);
        repeat (run_len) send_request(random_request());
      end
    end
    in_tvalid <= 1'b0;

    // drain owed results, then let the sequencer settle
    while (table_sb.owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d requests, %0d results checked, %0d fire results",
             sent, table_sb.checked, table_sb.fires);
    $display("largest tick burst %0d results, long receiver hold-off applied: %0d",
             table_sb.most_fires, hold_off_done);
    if (table_sb.mismatches == 0) begin
      $display("PASS software_timer_table_top");
    end else begin
      $display("FAIL software_timer_table_top");
    end
    $finish;
  end

endmodule
